FILE: sv/i2crts_pkg.sv
package i2crts_pkg;

	localparam int DEF_BUF_DEPTH = 16;
	localparam int CMP_W = 9;

	localparam logic [2:0] OP_TICK  = 3'd0;
	localparam logic [2:0] OP_LOAD  = 3'd1;
	localparam logic [2:0] OP_WRITE = 3'd2;
	localparam logic [2:0] OP_READ  = 3'd3;
	localparam logic [2:0] OP_FETCH = 3'd4;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_BUSY     = 2'd1;
	localparam logic [1:0] ST_NOT_RDY  = 2'd2;
	localparam logic [1:0] ST_BAD_CNT  = 2'd3;

	localparam logic [1:0] PH_IDLE = 2'd0;
	localparam logic [1:0] PH_BUSY = 2'd1;
	localparam logic [1:0] PH_DONE = 2'd2;

	localparam logic [7:0] DEV_RD_BIT = 8'h01;

	localparam logic [4:0] S_IDLE      = 5'd0;
	localparam logic [4:0] W_START     = 5'd1;
	localparam logic [4:0] W_TARGET    = 5'd2;
	localparam logic [4:0] W_ADDR      = 5'd3;
	localparam logic [4:0] W_CONTENT   = 5'd4;
	localparam logic [4:0] W_STOP      = 5'd5;
	localparam logic [4:0] W_CHECKSTOP = 5'd6;
	localparam logic [4:0] R_START     = 5'd7;
	localparam logic [4:0] R_TARGET    = 5'd8;
	localparam logic [4:0] R_ADDR      = 5'd9;
	localparam logic [4:0] R_STOP1     = 5'd10;
	localparam logic [4:0] R_RESTART   = 5'd11;
	localparam logic [4:0] R_RTARGET   = 5'd12;
	localparam logic [4:0] R_RXEN      = 5'd13;
	localparam logic [4:0] R_CONTENT   = 5'd14;
	localparam logic [4:0] R_ACK       = 5'd15;
	localparam logic [4:0] R_NACK      = 5'd16;
	localparam logic [4:0] R_STOP2     = 5'd17;
	localparam logic [4:0] R_CHECKSTOP = 5'd18;
	localparam logic [4:0] R_DONE      = 5'd19;

	typedef struct packed {
		logic accept;
		logic exec;
		logic fetch_rd;
		logic fetch_ld;
		logic fetch_next;
	} cmd_t;

	typedef struct packed {
		logic fetch_ok;
		logic res_last;
	} sts_t;

	typedef struct packed {
		logic [1:0] status;
		logic       do_start;
		logic       do_stop;
		logic       send_valid;
		logic [7:0] send_byte;
		logic       receive_enable;
		logic       ack_enable;
		logic       ack_is_nack;
		logic       clear_irq;
		logic [1:0] phase;
		logic [7:0] data_byte;
		logic       last;
	} res_t;

	function automatic logic [1:0] phase_of(input logic [4:0] s);
		if (s == S_IDLE) begin
			return PH_IDLE;
		end else if (s == R_DONE) begin
			return PH_DONE;
		end
		return PH_BUSY;
	endfunction

endpackage

FILE: sv/i2c_register_transaction_sequencer.sv
// Flow: an accepted item runs in state EXEC; its result is registered and offered
// in state OUT (a fetch passes FRD and FLD first). A new item is taken only in idle,
// after the last result is taken; a fetch streams its bytes through the store's
// registered read port, each via FRD, FLD and OUT, and the next item follows the last.
// Reset: arst_n clears the sequence to idle and the transfer position, count and
// addresses to zero; the byte store holds no reset value.
module i2c_register_transaction_sequencer #(
	parameter int BUF_DEPTH = i2crts_pkg::DEF_BUF_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [2:0] op,
	input  logic [7:0] target_addr,
	input  logic [7:0] data_addr,
	input  logic [4:0] count,
	input  logic [3:0] byte_index,
	input  logic [7:0] write_byte,
	input  logic       start_busy,
	input  logic       stop_busy,
	input  logic       ack_busy,
	input  logic       buffer_full,
	input  logic       transmitting,
	input  logic [7:0] rx_byte,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [1:0] status,
	output logic       do_start,
	output logic       do_stop,
	output logic       send_valid,
	output logic [7:0] send_byte,
	output logic       receive_enable,
	output logic       ack_enable,
	output logic       ack_is_nack,
	output logic       clear_irq,
	output logic [1:0] phase,
	output logic [7:0] data_byte,
	output logic       last
);
	import i2crts_pkg::*;

	cmd_t cmd;
	sts_t sts;
	res_t res;

	i2crts_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	i2crts_dp #(
		.BUF_DEPTH (BUF_DEPTH)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.op           (op),
		.target_addr  (target_addr),
		.data_addr    (data_addr),
		.count        (count),
		.byte_index   (byte_index),
		.write_byte   (write_byte),
		.start_busy   (start_busy),
		.stop_busy    (stop_busy),
		.ack_busy     (ack_busy),
		.buffer_full  (buffer_full),
		.transmitting (transmitting),
		.rx_byte      (rx_byte),
		.res          (res)
	);

	assign status = res.status;
	assign do_start = res.do_start;
	assign do_stop = res.do_stop;
	assign send_valid = res.send_valid;
	assign send_byte = res.send_byte;
	assign receive_enable = res.receive_enable;
	assign ack_enable = res.ack_enable;
	assign ack_is_nack = res.ack_is_nack;
	assign clear_irq = res.clear_irq;
	assign phase = res.phase;
	assign data_byte = res.data_byte;
	assign last = res.last;

endmodule

FILE: sv/i2crts_ctrl.sv
module i2crts_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	output logic                out_valid,
	input  logic                out_ready,
	input  i2crts_pkg::sts_t    sts,
	output i2crts_pkg::cmd_t    cmd
);
	import i2crts_pkg::*;

	localparam logic [2:0] C_IDLE = 3'd0;
	localparam logic [2:0] C_EXEC = 3'd1;
	localparam logic [2:0] C_FRD  = 3'd2;
	localparam logic [2:0] C_FLD  = 3'd3;
	localparam logic [2:0] C_OUT  = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_n;

	always_comb begin
		state_n = state_q;
		cmd = '0;
		in_ready = 1'b0;
		out_valid = 1'b0;
		unique case (state_q)
			C_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.accept = 1'b1;
					state_n = C_EXEC;
				end
			end
			C_EXEC: begin
				cmd.exec = 1'b1;
				state_n = sts.fetch_ok ? C_FRD : C_OUT;
			end
			C_FRD: begin
				cmd.fetch_rd = 1'b1;
				state_n = C_FLD;
			end
			C_FLD: begin
				cmd.fetch_ld = 1'b1;
				state_n = C_OUT;
			end
			C_OUT: begin
				out_valid = 1'b1;
				if (out_ready) begin
					if (sts.res_last) begin
						state_n = C_IDLE;
					end else begin
						cmd.fetch_next = 1'b1;
						state_n = C_FRD;
					end
				end
			end
			default: begin
				state_n = C_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= C_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

endmodule

FILE: sv/i2crts_dp.sv
module i2crts_dp #(
	parameter int BUF_DEPTH = i2crts_pkg::DEF_BUF_DEPTH
) (
	input  logic              clk,
	input  logic              arst_n,
	input  i2crts_pkg::cmd_t  cmd,
	output i2crts_pkg::sts_t  sts,
	input  logic [2:0]        op,
	input  logic [7:0]        target_addr,
	input  logic [7:0]        data_addr,
	input  logic [4:0]        count,
	input  logic [3:0]        byte_index,
	input  logic [7:0]        write_byte,
	input  logic              start_busy,
	input  logic              stop_busy,
	input  logic              ack_busy,
	input  logic              buffer_full,
	input  logic              transmitting,
	input  logic [7:0]        rx_byte,
	output i2crts_pkg::res_t  res
);
	import i2crts_pkg::*;

	localparam int AW = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;

	logic [2:0] op_q;
	logic [7:0] ta_q;
	logic [7:0] da_q;
	logic [4:0] cnt_q;
	logic [3:0] idx_q;
	logic [7:0] wb_q;
	logic       sb_q;
	logic       pb_q;
	logic       ab_q;
	logic       bf_q;
	logic       tx_q;
	logic [7:0] rx_q;

	logic [4:0] seq_q;
	logic [4:0] pos_q;
	logic [4:0] total_q;
	logic [7:0] dev_q;
	logic [7:0] reg_q;
	logic [AW-1:0] fidx_q;
	res_t res_q;

	logic [7:0] mem [BUF_DEPTH];
	logic [7:0] rd_q;
	logic [AW-1:0] rd_addr;

	logic [4:0] seq_n;
	logic [4:0] pos_n;
	logic       start_ok;
	logic       fetch_ok;
	logic       we;
	logic [AW-1:0] wa;
	logic [7:0] wd;
	logic       busy_line;
	logic [4:0] pos_inc;
	res_t       res_n;
	res_t       res_f;

	assign busy_line = bf_q | tx_q;
	assign pos_inc = pos_q + 5'd1;
	assign fetch_ok = (op_q == OP_FETCH) && (seq_q == R_DONE);
	assign sts.fetch_ok = fetch_ok;
	assign sts.res_last = res_q.last;
	assign res = res_q;
	assign rd_addr = cmd.fetch_rd ? fidx_q : AW'(pos_q);

	always_comb begin
		seq_n = seq_q;
		pos_n = pos_q;
		start_ok = 1'b0;
		we = 1'b0;
		wa = AW'(pos_q);
		wd = rx_q;
		res_n = '0;
		res_n.last = 1'b1;
		unique case (op_q) inside
			OP_TICK: begin
				unique case (seq_q) inside
					W_START, R_START: begin
						res_n.do_start = 1'b1;
						seq_n = (seq_q == W_START) ? W_TARGET : R_TARGET;
					end
					W_TARGET, R_TARGET: begin
						if (!sb_q) begin
							res_n.send_valid = 1'b1;
							res_n.send_byte = dev_q;
							seq_n = (seq_q == W_TARGET) ? W_ADDR : R_ADDR;
						end
					end
					W_ADDR, R_ADDR: begin
						if (!busy_line) begin
							res_n.send_valid = 1'b1;
							res_n.send_byte = reg_q;
							seq_n = (seq_q == W_ADDR) ? W_CONTENT : R_STOP1;
						end
					end
					W_CONTENT: begin
						if (!busy_line) begin
							res_n.send_valid = 1'b1;
							res_n.send_byte = rd_q;
							pos_n = pos_inc;
							if (pos_inc >= total_q) begin
								seq_n = W_STOP;
							end
						end
					end
					W_STOP, R_STOP1, R_STOP2: begin
						if (!busy_line) begin
							res_n.do_stop = 1'b1;
							if (seq_q == W_STOP) begin
								seq_n = W_CHECKSTOP;
							end else if (seq_q == R_STOP1) begin
								seq_n = R_RESTART;
							end else begin
								seq_n = R_CHECKSTOP;
							end
						end
					end
					W_CHECKSTOP: begin
						if (!pb_q) begin
							seq_n = S_IDLE;
						end
					end
					R_RESTART: begin
						if (!pb_q) begin
							res_n.do_start = 1'b1;
							seq_n = R_RTARGET;
						end
					end
					R_RTARGET: begin
						if (!sb_q) begin
							res_n.send_valid = 1'b1;
							res_n.send_byte = dev_q | DEV_RD_BIT;
							seq_n = R_RXEN;
						end
					end
					R_RXEN: begin
						if (!busy_line) begin
							res_n.receive_enable = 1'b1;
							seq_n = R_CONTENT;
						end
					end
					R_CONTENT: begin
						if (bf_q) begin
							we = CMP_W'(pos_q) < CMP_W'(BUF_DEPTH);
							pos_n = pos_inc;
							res_n.ack_enable = 1'b1;
							if (pos_inc >= total_q) begin
								res_n.ack_is_nack = 1'b1;
								seq_n = R_NACK;
							end else begin
								seq_n = R_ACK;
							end
						end
					end
					R_ACK, R_NACK: begin
						if (!(ab_q || busy_line)) begin
							if (seq_q == R_ACK) begin
								res_n.receive_enable = 1'b1;
								seq_n = R_CONTENT;
							end else begin
								seq_n = R_STOP2;
							end
						end
					end
					R_CHECKSTOP: begin
						if (!pb_q) begin
							res_n.clear_irq = 1'b1;
							seq_n = R_DONE;
						end
					end
					default: begin
					end
				endcase
			end
			OP_LOAD: begin
				if (seq_q != S_IDLE) begin
					res_n.status = ST_BUSY;
				end else if (CMP_W'(idx_q) >= CMP_W'(BUF_DEPTH)) begin
					res_n.status = ST_BAD_CNT;
				end else begin
					we = 1'b1;
					wa = AW'(idx_q);
					wd = wb_q;
				end
			end
			OP_WRITE, OP_READ: begin
				if (seq_q != S_IDLE) begin
					res_n.status = ST_BUSY;
				end else if (cnt_q == 5'd0 || CMP_W'(cnt_q) > CMP_W'(BUF_DEPTH)) begin
					res_n.status = ST_BAD_CNT;
				end else begin
					start_ok = 1'b1;
					pos_n = 5'd0;
					seq_n = (op_q == OP_WRITE) ? W_START : R_START;
				end
			end
			OP_FETCH: begin
				if (seq_q != R_DONE) begin
					res_n.status = ST_NOT_RDY;
				end else begin
					seq_n = S_IDLE;
				end
			end
			default: begin
			end
		endcase
		res_n.phase = phase_of(seq_n);
	end

	always_comb begin
		res_f = '0;
		res_f.status = ST_OK;
		res_f.phase = PH_IDLE;
		res_f.data_byte = rd_q;
		res_f.last = (CMP_W'(fidx_q) + CMP_W'(1)) == CMP_W'(total_q);
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			op_q <= op;
			ta_q <= target_addr;
			da_q <= data_addr;
			cnt_q <= count;
			idx_q <= byte_index;
			wb_q <= write_byte;
			sb_q <= start_busy;
			pb_q <= stop_busy;
			ab_q <= ack_busy;
			bf_q <= buffer_full;
			tx_q <= transmitting;
			rx_q <= rx_byte;
		end
		if (cmd.exec && !fetch_ok) begin
			res_q <= res_n;
		end else if (cmd.fetch_ld) begin
			res_q <= res_f;
		end
		if (cmd.exec && fetch_ok) begin
			fidx_q <= '0;
		end else if (cmd.fetch_next) begin
			fidx_q <= fidx_q + AW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec && we) begin
			mem[wa] <= wd;
		end
		rd_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_q <= S_IDLE;
			pos_q <= '0;
			total_q <= '0;
			dev_q <= '0;
			reg_q <= '0;
		end else if (cmd.exec) begin
			seq_q <= seq_n;
			pos_q <= pos_n;
			if (start_ok) begin
				total_q <= cnt_q;
				dev_q <= ta_q;
				reg_q <= da_q;
			end
		end
	end

endmodule

FILE: sim/i2c_register_transaction_sequencer_tb.sv
module i2c_register_transaction_sequencer_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import i2crts_pkg::*;

	localparam int CLK_PERIOD   = 10;
	localparam int RESET_CYCLES = 4;
	localparam int HOLD_CYCLES  = 80;
	localparam int DRAIN_CYCLES = 20;
	localparam int ITEM_GOAL    = 150;
	localparam int NO_GAP_ITEMS = 30;
	localparam int CYCLE_LIMIT  = 100000;
	localparam int GAP_PCT      = 34;
	localparam int STORE_DEPTH  = DEF_BUF_DEPTH;

	localparam logic [2:0] OP_SPARE_FIRST = 3'd5;
	localparam logic [2:0] OP_SPARE_LAST  = 3'd7;

	typedef enum int {CALM_IDLE, IN_FLIGHT, READ_HELD} noise_ctx_e;

	typedef struct {
		logic [2:0] op;
		logic [7:0] target_addr;
		logic [7:0] data_addr;
		logic [4:0] count;
		logic [3:0] byte_index;
		logic [7:0] write_byte;
		logic       start_busy;
		logic       stop_busy;
		logic       ack_busy;
		logic       buffer_full;
		logic       transmitting;
		logic [7:0] rx_byte;
	} bus_item_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	logic [2:0] op = '0;
	logic [7:0] target_addr = '0;
	logic [7:0] data_addr = '0;
	logic [4:0] count = '0;
	logic [3:0] byte_index = '0;
	logic [7:0] write_byte = '0;
	logic       start_busy = 1'b0;
	logic       stop_busy = 1'b0;
	logic       ack_busy = 1'b0;
	logic       buffer_full = 1'b0;
	logic       transmitting = 1'b0;
	logic [7:0] rx_byte = '0;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic [1:0] status;
	logic       do_start;
	logic       do_stop;
	logic       send_valid;
	logic [7:0] send_byte;
	logic       receive_enable;
	logic       ack_enable;
	logic       ack_is_nack;
	logic       clear_irq;
	logic [1:0] phase;
	logic [7:0] data_byte;
	logic       last;

	logic [4:0] seq_st = S_IDLE;
	logic [7:0] mem [STORE_DEPTH];
	logic       mem_loaded [STORE_DEPTH];
	logic [4:0] xfer_total = '0;
	logic [4:0] xfer_pos = '0;
	logic [7:0] dev_addr = '0;
	logic [7:0] reg_addr = '0;

	bus_item_t cmd_fifo [$];
	res_t      awaited_results [$];
	bus_item_t offered;

	int  items_pushed = 0;
	int  items_taken = 0;
	int  results_checked = 0;
	int  failures = 0;
	int  writes_started = 0;
	int  reads_started = 0;
	int  bytes_fetched = 0;
	int  cycle_count = 0;
	int  hold_left = 0;
	logic gaps_on = 1'b1;
	logic hold_kick = 1'b0;
	logic hold_seen = 1'b0;

	i2c_register_transaction_sequencer i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.op            (op),
		.target_addr   (target_addr),
		.data_addr     (data_addr),
		.count         (count),
		.byte_index    (byte_index),
		.write_byte    (write_byte),
		.start_busy    (start_busy),
		.stop_busy     (stop_busy),
		.ack_busy      (ack_busy),
		.buffer_full   (buffer_full),
		.transmitting  (transmitting),
		.rx_byte       (rx_byte),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.status        (status),
		.do_start      (do_start),
		.do_stop       (do_stop),
		.send_valid    (send_valid),
		.send_byte     (send_byte),
		.receive_enable(receive_enable),
		.ack_enable    (ack_enable),
		.ack_is_nack   (ack_is_nack),
		.clear_irq     (clear_irq),
		.phase         (phase),
		.data_byte     (data_byte),
		.last          (last)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	initial begin
		for (int k = 0; k < STORE_DEPTH; k++) begin
			mem_loaded[k] = 1'b0;
		end
	end

	function automatic void step_sequencer(input bus_item_t c);
		res_t r;
		logic line_busy;
		r = '0;
		r.status = ST_OK;
		r.last = 1'b1;
		line_busy = c.buffer_full | c.transmitting;
		case (c.op) inside
			OP_TICK: begin
				case (seq_st) inside
					W_START, R_START: begin
						r.do_start = 1'b1;
						seq_st = (seq_st == W_START) ? W_TARGET : R_TARGET;
					end
					W_TARGET, R_TARGET: begin
						if (!c.start_busy) begin
							r.send_valid = 1'b1;
							r.send_byte = dev_addr;
							seq_st = (seq_st == W_TARGET) ? W_ADDR : R_ADDR;
						end
					end
					W_ADDR, R_ADDR: begin
						if (!line_busy) begin
							r.send_valid = 1'b1;
							r.send_byte = reg_addr;
							seq_st = (seq_st == W_ADDR) ? W_CONTENT : R_STOP1;
						end
					end
					W_CONTENT: begin
						if (!line_busy) begin
							r.send_valid = 1'b1;
							r.send_byte = mem[xfer_pos[3:0]];
							xfer_pos = xfer_pos + 5'd1;
							if (xfer_pos >= xfer_total) begin
								seq_st = W_STOP;
							end
						end
					end
					W_STOP, R_STOP1, R_STOP2: begin
						if (!line_busy) begin
							r.do_stop = 1'b1;
							if (seq_st == W_STOP) begin
								seq_st = W_CHECKSTOP;
							end else if (seq_st == R_STOP1) begin
								seq_st = R_RESTART;
							end else begin
								seq_st = R_CHECKSTOP;
							end
						end
					end
					W_CHECKSTOP: begin
						if (!c.stop_busy) begin
							seq_st = S_IDLE;
						end
					end
					R_RESTART: begin
						if (!c.stop_busy) begin
							r.do_start = 1'b1;
							seq_st = R_RTARGET;
						end
					end
					R_RTARGET: begin
						if (!c.start_busy) begin
							r.send_valid = 1'b1;
							r.send_byte = dev_addr | DEV_RD_BIT;
							seq_st = R_RXEN;
						end
					end
					R_RXEN: begin
						if (!line_busy) begin
							r.receive_enable = 1'b1;
							seq_st = R_CONTENT;
						end
					end
					R_CONTENT: begin
						if (c.buffer_full) begin
							mem[xfer_pos[3:0]] = c.rx_byte;
							mem_loaded[xfer_pos[3:0]] = 1'b1;
							xfer_pos = xfer_pos + 5'd1;
							r.ack_enable = 1'b1;
							if (xfer_pos >= xfer_total) begin
								r.ack_is_nack = 1'b1;
								seq_st = R_NACK;
							end else begin
								seq_st = R_ACK;
							end
						end
					end
					R_ACK, R_NACK: begin
						if (!(c.ack_busy || line_busy)) begin
							if (seq_st == R_ACK) begin
								r.receive_enable = 1'b1;
								seq_st = R_CONTENT;
							end else begin
								seq_st = R_STOP2;
							end
						end
					end
					R_CHECKSTOP: begin
						if (!c.stop_busy) begin
							r.clear_irq = 1'b1;
							seq_st = R_DONE;
						end
					end
					default: begin
					end
				endcase
			end
			OP_LOAD: begin
				if (seq_st != S_IDLE) begin
					r.status = ST_BUSY;
				end else begin
					mem[c.byte_index] = c.write_byte;
					mem_loaded[c.byte_index] = 1'b1;
				end
			end
			OP_WRITE, OP_READ: begin
				if (seq_st != S_IDLE) begin
					r.status = ST_BUSY;
				end else if (c.count == 5'd0 || c.count > STORE_DEPTH) begin
					r.status = ST_BAD_CNT;
				end else begin
					dev_addr = c.target_addr;
					reg_addr = c.data_addr;
					xfer_total = c.count;
					xfer_pos = '0;
					if (c.op == OP_WRITE) begin
						seq_st = W_START;
						writes_started++;
					end else begin
						seq_st = R_START;
						reads_started++;
					end
				end
			end
			OP_FETCH: begin
				if (seq_st != R_DONE) begin
					r.status = ST_NOT_RDY;
				end else begin
					seq_st = S_IDLE;
					r.phase = PH_IDLE;
					for (int k = 0; k < xfer_total; k++) begin
						r.data_byte = mem[k];
						r.last = (k == xfer_total - 1);
						awaited_results.push_back(r);
					end
					bytes_fetched += xfer_total;
					return;
				end
			end
			default: begin
			end
		endcase
		r.phase = (seq_st == S_IDLE) ? PH_IDLE : (seq_st == R_DONE) ? PH_DONE : PH_BUSY;
		awaited_results.push_back(r);
	endfunction

	task automatic check_field(input string name, input logic [7:0] got, input logic [7:0] want);
		if (got !== want) begin
			$display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h", $time, name, want, got);
			failures++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				step_sequencer(offered);
				items_taken <= items_taken + 1;
			end
			if (!in_valid || in_ready) begin
				if (cmd_fifo.size() > 0 && !(gaps_on && $urandom_range(99) < GAP_PCT)) begin
					offered = cmd_fifo.pop_front();
					op <= offered.op;
					target_addr <= offered.target_addr;
					data_addr <= offered.data_addr;
					count <= offered.count;
					byte_index <= offered.byte_index;
					write_byte <= offered.write_byte;
					start_busy <= offered.start_busy;
					stop_busy <= offered.stop_busy;
					ack_busy <= offered.ack_busy;
					buffer_full <= offered.buffer_full;
					transmitting <= offered.transmitting;
					rx_byte <= offered.rx_byte;
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			hold_seen <= 1'b0;
			hold_left <= 0;
		end else if (hold_kick != hold_seen) begin
			hold_seen <= hold_kick;
			hold_left <= HOLD_CYCLES;
			out_ready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= !(gaps_on && $urandom_range(99) < GAP_PCT);
		end
	end

	always @(posedge clk) begin
		res_t want;
		if (arst_n && out_valid && out_ready) begin
			if (awaited_results.size() == 0) begin
				$display("%0t: unexpected transfer: expected none, actual status %0d data 0x%0h",
					$time, status, data_byte);
				failures++;
			end else begin
				want = awaited_results.pop_front();
				check_field("status", 8'(status), 8'(want.status));
				check_field("do_start", 8'(do_start), 8'(want.do_start));
				check_field("do_stop", 8'(do_stop), 8'(want.do_stop));
				check_field("send_valid", 8'(send_valid), 8'(want.send_valid));
				check_field("send_byte", send_byte, want.send_byte);
				check_field("receive_enable", 8'(receive_enable), 8'(want.receive_enable));
				check_field("ack_enable", 8'(ack_enable), 8'(want.ack_enable));
				check_field("ack_is_nack", 8'(ack_is_nack), 8'(want.ack_is_nack));
				check_field("clear_irq", 8'(clear_irq), 8'(want.clear_irq));
				check_field("phase", 8'(phase), 8'(want.phase));
				check_field("data_byte", data_byte, want.data_byte);
				check_field("last", 8'(last), 8'(want.last));
				results_checked++;
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	function automatic bus_item_t random_cmd();
		bus_item_t c;
		c.op = OP_TICK;
		c.target_addr = 8'($urandom_range(255));
		c.data_addr = 8'($urandom_range(255));
		c.count = 5'($urandom_range(31));
		c.byte_index = 4'($urandom_range(15));
		c.write_byte = 8'($urandom_range(255));
		c.start_busy = 1'($urandom_range(1));
		c.stop_busy = 1'($urandom_range(1));
		c.ack_busy = 1'($urandom_range(1));
		c.buffer_full = 1'($urandom_range(1));
		c.transmitting = 1'($urandom_range(1));
		c.rx_byte = 8'($urandom_range(255));
		return c;
	endfunction

	task automatic push_cmd(input bus_item_t c);
		cmd_fifo.push_back(c);
		items_pushed++;
	endtask

	task automatic push_tick();
		bus_item_t c;
		c = random_cmd();
		c.start_busy = ($urandom_range(99) < 25);
		c.stop_busy = ($urandom_range(99) < 25);
		c.ack_busy = ($urandom_range(99) < 25);
		c.transmitting = ($urandom_range(99) < 25);
		c.buffer_full = ($urandom_range(99) < 40);
		push_cmd(c);
	endtask

	task automatic push_load(input int idx, input logic [7:0] value);
		bus_item_t c;
		c = random_cmd();
		c.op = OP_LOAD;
		c.byte_index = 4'(idx);
		c.write_byte = value;
		push_cmd(c);
	endtask

	task automatic push_start(input logic [2:0] kind, input int n, input logic [7:0] dev,
		input logic [7:0] regn);
		bus_item_t c;
		c = random_cmd();
		c.op = kind;
		c.count = 5'(n);
		c.target_addr = dev;
		c.data_addr = regn;
		push_cmd(c);
	endtask

	task automatic push_opcode(input logic [2:0] kind);
		bus_item_t c;
		c = random_cmd();
		c.op = kind;
		push_cmd(c);
	endtask

	task automatic sync_up();
		while (items_taken != items_pushed) @(posedge clk);
	endtask

	task automatic run_to(input logic [4:0] goal, input int batch);
		int rounds;
		rounds = 0;
		sync_up();
		while (seq_st != goal && rounds < 200) begin
			repeat (batch) push_tick();
			sync_up();
			rounds++;
		end
	endtask

	// keep each context's noise from leaving it: no accepted start, no fetch once read is held
	task automatic push_noise(input noise_ctx_e ctx, input int n);
		bus_item_t c;
		int pick;
		for (int k = 0; k < n; k++) begin
			c = random_cmd();
			pick = $urandom_range((ctx == READ_HELD) ? 3 : 4);
			case (pick)
				0: c.op = OP_LOAD;
				1: begin
					c.op = $urandom_range(1) ? OP_WRITE : OP_READ;
					if (ctx == CALM_IDLE) begin
						c.count = $urandom_range(1) ? 5'd0 : 5'($urandom_range(31, 17));
					end
				end
				2: c.op = 3'($urandom_range(OP_SPARE_LAST, OP_SPARE_FIRST));
				3: c.op = OP_TICK;
				default: c.op = OP_FETCH;
			endcase
			push_cmd(c);
		end
	endtask

	task automatic run_write(input int n, input logic [7:0] dev, input logic [7:0] regn);
		sync_up();
		for (int k = 0; k < n; k++) begin
			if (!mem_loaded[k] || $urandom_range(1)) begin
				push_load(k, 8'($urandom_range(255)));
			end
		end
		push_start(OP_WRITE, n, dev, regn);
		push_noise(IN_FLIGHT, $urandom_range(3, 1));
		run_to(S_IDLE, 4);
	endtask

	task automatic run_read(input int n, input logic [7:0] dev, input logic [7:0] regn,
		input int batch);
		push_start(OP_READ, n, dev, regn);
		push_noise(IN_FLIGHT, $urandom_range(3, 1));
		run_to(R_DONE, batch);
		push_noise(READ_HELD, $urandom_range(2));
		push_opcode(OP_FETCH);
	endtask

	initial begin
		bus_item_t c;
		int pick;
		int nbytes;
		int loop_base;

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		c = random_cmd();
		c.start_busy = 1'b1;
		c.stop_busy = 1'b1;
		c.ack_busy = 1'b1;
		c.buffer_full = 1'b1;
		c.transmitting = 1'b1;
		c.rx_byte = 8'hFF;
		push_cmd(c);
		push_opcode(OP_FETCH);
		for (int k = OP_SPARE_FIRST; k <= OP_SPARE_LAST; k++) begin
			push_opcode(3'(k));
		end
		push_start(OP_WRITE, 0, 8'hFE, 8'hFF);
		push_start(OP_READ, 17, 8'h00, 8'h00);
		push_start(OP_WRITE, 31, 8'hFF, 8'h00);
		push_load(0, 8'hFF);
		push_load(15, 8'h00);
		run_write(1, 8'hFE, 8'hFF);
		run_read(1, 8'h00, 8'h00, 4);

		// stall the result side while ticks keep coming
		hold_kick <= ~hold_kick;
		run_read(4, 8'($urandom_range(255)), 8'($urandom_range(255)), 4);

		loop_base = items_pushed;
		while (items_pushed < ITEM_GOAL) begin
			gaps_on <= !(items_pushed - loop_base < NO_GAP_ITEMS);
			pick = $urandom_range(99);
			nbytes = ($urandom_range(99) < 8) ? STORE_DEPTH : $urandom_range(4, 1);
			if (pick < 45) begin
				run_write(nbytes, 8'($urandom_range(255)), 8'($urandom_range(255)));
			end else if (pick < 80) begin
				run_read(nbytes, 8'($urandom_range(255)), 8'($urandom_range(255)), 4);
			end else begin
				push_noise(CALM_IDLE, $urandom_range(6, 2));
			end
		end
		gaps_on <= 1'b1;

		sync_up();
		while (awaited_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d commands: %0d register writes and %0d register reads started,",
			items_pushed, writes_started, reads_started);
		$display("%0d bytes fetched, %0d results compared, %0d mismatches.",
			bytes_fetched, results_checked, failures);
		if (failures == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
